FILE: hw/rtl/vlw_pkg.sv
// ----------------------------------------------------------------------------
// vlw_pkg
// Shared constants and types for the 3D voxel line walker.
// ----------------------------------------------------------------------------
package vlw_pkg;

  localparam int COORD_BITS = 16;
  localparam int MAX_STEPS  = 63;
  localparam int STEP_BITS  = 6;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [STEP_BITS-1:0]         step_t;

  typedef struct packed {
    logic load;
    logic adv;
  } lane_ctrl_t;

endpackage

FILE: hw/rtl/vlw_axis.sv
// ----------------------------------------------------------------------------
// vlw_axis
// One axis of the walker: incremental quotient/remainder of i*d/steps and
// exact half-away-from-zero rounding of start + i*d/steps.
// ----------------------------------------------------------------------------
module vlw_axis (
  input  logic               clk,
  input  vlw_pkg::lane_ctrl_t ctrl,
  input  vlw_pkg::coord_t    start,
  input  vlw_pkg::coord_t    stop,
  input  vlw_pkg::step_t     steps,
  output logic [vlw_pkg::COORD_BITS-1:0] mag,
  output vlw_pkg::coord_t    voxel
);
  import vlw_pkg::*;

  logic signed [COORD_BITS:0] diff;
  logic signed [COORD_BITS:0] w;
  logic                       neg;
  step_t                      r;
  logic [STEP_BITS:0]         sum;
  logic [STEP_BITS:0]         twice_r;
  logic signed [COORD_BITS:0] rounded;

  assign diff    = {stop[COORD_BITS-1], stop} - {start[COORD_BITS-1], start};
  assign sum     = {1'b0, r} + {1'b0, mag[STEP_BITS-1:0]};
  assign twice_r = {r, 1'b0};

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      w   <= {start[COORD_BITS-1], start};
      neg <= diff[COORD_BITS];
      mag <= diff[COORD_BITS] ? COORD_BITS'(-diff) : diff[COORD_BITS-1:0];
      r   <= '0;
    end else if (ctrl.adv) begin
      if (sum >= {1'b0, steps}) begin
        r <= STEP_BITS'(sum - {1'b0, steps});
        w <= neg ? w - 1'b1 : w + 1'b1;
      end else begin
        r <= sum[STEP_BITS-1:0];
      end
    end
  end

  // above half: step w by the sign; exact half: w + sign/2, rounded away from zero
  always_comb begin
    rounded = w;
    if (twice_r > {1'b0, steps}) begin
      rounded = neg ? w - 1'b1 : w + 1'b1;
    end else if (twice_r == {1'b0, steps} && steps != '0) begin
      if (neg) begin
        if (w <= 0) rounded = w - 1'b1;
      end else begin
        if (w >= 0) rounded = w + 1'b1;
      end
    end
  end

  assign voxel = rounded[COORD_BITS-1:0];

endmodule

FILE: hw/rtl/voxel_line_walker_3d_core.sv
// ----------------------------------------------------------------------------
// voxel_line_walker_3d_core
// Emits the voxels on the straight line between two signed 3D voxels.
// ----------------------------------------------------------------------------
// One line is accepted, sized in the following cycle, then its steps+1 voxels
// leave one per cycle from the output register while the sink keeps tready
// high; a line longer than MAX_STEPS gives one result with tuser set instead.
// The per-axis step units advance one voxel per cycle while the output
// register is free. A new line is taken as soon as the final voxel sits in
// the output register.
module voxel_line_walker_3d_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z
  input  logic [95:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // voxel_x, voxel_y, voxel_z, step_index, 2'b0
  output logic [55:0] m_tdata,
  output logic        m_tlast,   // last_point
  // too_long
  output logic [0:0]  m_tuser
);
  import vlw_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SIZE  = 2'd1;
  localparam logic [1:0] S_EMIT  = 2'd2;
  localparam logic [1:0] S_FAULT = 2'd3;

  logic [1:0]  state;
  step_t       steps;
  step_t       cnt;
  lane_ctrl_t  lane_ctrl;
  logic        accept;
  logic        slot_free;
  logic        last;
  logic [COORD_BITS-1:0] mag [3];
  coord_t      voxel [3];
  logic [COORD_BITS-1:0] mag_xy;
  logic [COORD_BITS-1:0] mag_max;

  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign slot_free = !m_tvalid || m_tready;
  assign last      = (cnt == steps);

  assign lane_ctrl.load = accept;
  assign lane_ctrl.adv  = (state == S_EMIT) && slot_free;

  for (genvar k = 0; k < 3; k++) begin : g_axis
    vlw_axis u_axis (
      .clk   (clk),
      .ctrl  (lane_ctrl),
      .start (s_tdata[k*COORD_BITS +: COORD_BITS]),
      .stop  (s_tdata[(k+3)*COORD_BITS +: COORD_BITS]),
      .steps (steps),
      .mag   (mag[k]),
      .voxel (voxel[k])
    );
  end

  assign mag_xy  = (mag[0] > mag[1]) ? mag[0] : mag[1];
  assign mag_max = (mag_xy > mag[2]) ? mag_xy : mag[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      steps    <= '0;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if ((state == S_EMIT || state == S_FAULT) && slot_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) state <= S_SIZE;
        end
        S_SIZE: begin
          cnt <= '0;
          if (mag_max > COORD_BITS'(MAX_STEPS)) begin
            state <= S_FAULT;
          end else begin
            steps <= mag_max[STEP_BITS-1:0];
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            cnt <= cnt + 1'b1;
            if (last) state <= S_IDLE;
          end
        end
        S_FAULT: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (state == S_EMIT) begin
        m_tdata <= {2'b00, cnt, voxel[2], voxel[1], voxel[0]};
        m_tlast <= last;
        m_tuser <= 1'b0;
      end else if (state == S_FAULT) begin
        m_tdata <= '0;
        m_tlast <= 1'b0;
        m_tuser <= 1'b1;
      end
    end
  end

  a_accept_sizes: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_SIZE)
    else $error("accepted line not sized");

  a_fault_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> !m_tlast && m_tdata == '0)
    else $error("too-long result carries voxel data");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT && m_tvalid && m_tlast |-> cnt == '0)
    else $error("final voxel sent while run still active");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |-> cnt <= steps)
    else $error("step counter overran line length");

endmodule
